FILE: rtl/core/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg
// Shared constants and types for the rotation matrix renormalize unit.
// ----------------------------------------------------------------------------
package rmr_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int ENT_W         = 32;
    localparam int QUO_W         = 32;

    typedef logic signed [ENT_W-1:0] ent_t;

    // one matrix, index is row * 3 + column
    typedef ent_t mat_t [9];

    // matrix plus the zero-divisor flag as it travels down the pipeline
    typedef struct packed {
        logic [9*ENT_W-1:0] ents;
        logic               deg;
    } carry_t;

endpackage

FILE: rtl/core/rmr_div.sv
// ----------------------------------------------------------------------------
// rmr_div
// Pipelined restoring divider: (mag * 2^FRAC_BITS) / den, one quotient bit
// per stage, with an overflow flag for quotients of 2^32 and above.
// ----------------------------------------------------------------------------
module rmr_div
    import rmr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NUM_W     = 66 - FRAC_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [NUM_W-1:0] mag,
    input  logic             neg,
    input  logic [NUM_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic             neg_out
);

    localparam int TOT_W = NUM_W + FRAC_BITS;

    logic [TOT_W-1:0] dividend;
    logic [TOT_W-1:0] hi_ext;
    logic [TOT_W-1:0] den_ext;
    logic             ovf0;

    logic [NUM_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic [NUM_W-1:0] den_reg [QUO_W+1];
    logic             ovf_reg [QUO_W+1];
    logic             neg_reg [QUO_W+1];

    assign dividend = {mag, {FRAC_BITS{1'b0}}};
    assign hi_ext   = dividend >> QUO_W;
    assign den_ext  = TOT_W'(den);
    assign ovf0     = hi_ext >= den_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= NUM_W'(hi_ext);
            low_reg[0] <= dividend[QUO_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf0;
            neg_reg[0] <= neg;
            for (int k = 1; k <= QUO_W; k++)
            begin
                logic [NUM_W:0] rem2;
                logic           ge;
                rem2 = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
                ge   = rem2 >= {1'b0, den_reg[k-1]};
                rem_reg[k] <= ge ? NUM_W'(rem2 - {1'b0, den_reg[k-1]}) : NUM_W'(rem2);
                low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QUO_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo     = q_reg[QUO_W];
    assign ovf     = ovf_reg[QUO_W];
    assign neg_out = neg_reg[QUO_W];

    // remainder stays below the divisor once the quotient fits
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!ovf_reg[QUO_W-1] && den_reg[QUO_W-1] != '0) |-> rem_reg[QUO_W-1] < den_reg[QUO_W-1])
        else $error("divider remainder out of range");

    a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (!ovf_reg[0] && den_reg[0] != '0) |-> rem_reg[0] < den_reg[0])
        else $error("divider initial remainder out of range");

endmodule

FILE: rtl/core/rotation_matrix_renormalize_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_renormalize_unit
// First-order orthonormalization of a 3x3 Q1.30 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one matrix per request, nine signed 32-bit entries, row 0
//   column 0 in the lowest bits, row-major. m_axis returns the corrected
//   matrix in the same layout, each entry clamped to [-1, 1]; tuser is set
//   when a column norm or a norm sum is zero, and then the matrix passes
//   through unchanged.
//   One matrix is taken per cycle while the output is not stalled. The six
//   divisions run in 33-stage bit-per-cycle divider pipelines, which set
//   most of the latency; the other stages hold one multiply or one wide
//   add each.
//   The whole pipeline advances together: when the result at the output
//   register is not taken, every stage holds and s_axis_tready drops; bubbles
//   travel as cleared valid bits.
//   Reset clears all valid bits; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module rotation_matrix_renormalize_unit
    import rmr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // in_r0_c0, in_r0_c1, ... in_r2_c2, 32 bits each
    input  logic [9*ENT_W-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_r0_c0, out_r0_c1, ... out_r2_c2, 32 bits each
    output logic [9*ENT_W-1:0]   m_axis_tdata,
    // degenerate
    output logic                 m_axis_tuser
);

    localparam int NUM_W  = 66 - FRAC_BITS;
    localparam int DIV_L  = QUO_W + 1;
    localparam int LAT    = DIV_L + 9;
    localparam int CAR_N  = LAT - 1;
    localparam int T_DIV  = 2;
    localparam int T_FAC  = T_DIV + DIV_L;
    localparam logic signed [65:0] ONE   = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] S_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S_MIN = -66'sd2147483648;

    logic         en;
    logic         vld_reg [LAT];
    carry_t       car_reg [CAR_N];
    mat_t         m_in;
    mat_t         m_t [CAR_N];

    logic signed [63:0] sq_reg [9];
    logic signed [63:0] dp_reg [9];
    logic signed [NUM_W-1:0] n_reg [3];
    logic signed [NUM_W-1:0] d_reg [3];

    logic signed [NUM_W-1:0] num [6];
    logic        [NUM_W-1:0] dmag [6];
    logic        [NUM_W-1:0] dden [6];
    logic        [QUO_W-1:0] dquo [6];
    logic                    dovf [6];
    logic                    dneg [6];
    logic signed [ENT_W-1:0] e_reg [6];

    logic signed [63:0] p0_reg [9];
    ent_t               r0_reg [3];
    logic signed [63:0] p1_reg [9];
    ent_t               r1_reg [3];
    logic signed [63:0] p2_reg [9];
    logic [9*ENT_W-1:0] out_reg;
    logic               deg_out_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = deg_out_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            m_in[i] = s_axis_tdata[i*ENT_W +: ENT_W];
        end
        for (int k = 0; k < CAR_N; k++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_t[k][i] = car_reg[k].ents[i*ENT_W +: ENT_W];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // matrix and degenerate flag travel alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_reg[0] <= '{ents: s_axis_tdata, deg: 1'b0};
            car_reg[1] <= car_reg[0];
            car_reg[T_DIV] <= '{ents: car_reg[1].ents,
                                deg: (n_reg[0] == '0) || (n_reg[1] == '0) ||
                                     (n_reg[2] == '0)};
            for (int k = T_DIV + 1; k < CAR_N; k++)
            begin
                car_reg[k] <= car_reg[k-1];
            end
        end
    end

    // products for norms and dot products, floored
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sq_reg[r*3+c] <= (64'(m_in[r*3+c]) * 64'(m_in[r*3+c])) >>> FRAC_BITS;
                end
                dp_reg[r*3+0] <= (64'(m_in[r*3+0]) * 64'(m_in[r*3+1])) >>> FRAC_BITS;
                dp_reg[r*3+1] <= (64'(m_in[r*3+0]) * 64'(m_in[r*3+2])) >>> FRAC_BITS;
                dp_reg[r*3+2] <= (64'(m_in[r*3+1]) * 64'(m_in[r*3+2])) >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c] <= NUM_W'(sq_reg[c] + sq_reg[3+c] + sq_reg[6+c]);
                d_reg[c] <= NUM_W'(dp_reg[c] + dp_reg[3+c] + dp_reg[6+c]);
            end
        end
    end

    // numerators and divisors
    always_comb
    begin
        num[0]  = NUM_W'(ONE) - n_reg[0];
        num[1]  = NUM_W'(ONE) - n_reg[1];
        num[2]  = NUM_W'(ONE) - n_reg[2];
        num[3]  = -d_reg[0];
        num[4]  = -d_reg[1];
        num[5]  = -d_reg[2];
        dden[0] = n_reg[0];
        dden[1] = n_reg[1];
        dden[2] = n_reg[2];
        dden[3] = n_reg[0] + n_reg[1];
        dden[4] = n_reg[0] + n_reg[2];
        dden[5] = n_reg[1] + n_reg[2];
        for (int k = 0; k < 6; k++)
        begin
            dmag[k] = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_div
        rmr_div #(
            .FRAC_BITS (FRAC_BITS),
            .NUM_W     (NUM_W)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .mag     (dmag[g]),
            .neg     (num[g][NUM_W-1]),
            .den     (dden[g]),
            .quo     (dquo[g]),
            .ovf     (dovf[g]),
            .neg_out (dneg[g])
        );
    end

    // sign and saturate the quotients; factor order e00 e11 e22 e01 e02 e12
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (!dneg[k])
                begin
                    e_reg[k] <= (dovf[k] || dquo[k][QUO_W-1]) ? ENT_W'(S_MAX)
                                                              : ENT_W'(dquo[k]);
                end
                else
                begin
                    e_reg[k] <= (dovf[k] || dquo[k] > 32'h8000_0000) ? ENT_W'(S_MIN)
                                                                     : ENT_W'(-dquo[k]);
                end
            end
        end
    end

    // column 0
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p0_reg[r*3+0] <= (64'(e_reg[0]) * 64'(m_t[T_FAC][r*3+0])) >>> FRAC_BITS;
                p0_reg[r*3+1] <= (64'(e_reg[3]) * 64'(m_t[T_FAC][r*3+1])) >>> FRAC_BITS;
                p0_reg[r*3+2] <= (64'(e_reg[4]) * 64'(m_t[T_FAC][r*3+2])) >>> FRAC_BITS;
            end
        end
    end

    logic signed [65:0] s0 [3];
    logic signed [65:0] s1 [3];
    logic signed [65:0] s2 [3];
    logic signed [ENT_W-1:0] e1_reg [6];
    logic signed [ENT_W-1:0] e2_reg [6];
    logic signed [ENT_W-1:0] e3_reg [6];
    logic signed [ENT_W-1:0] e4_reg [6];

    // factors follow the columns down the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg <= e_reg;
            e2_reg <= e1_reg;
            e3_reg <= e2_reg;
            e4_reg <= e3_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s0[r] = 66'(m_t[T_FAC+1][r*3+0]) + 66'(p0_reg[r*3+0]) + 66'(p0_reg[r*3+1])
                  + 66'(p0_reg[r*3+2]);
            s1[r] = 66'(m_t[T_FAC+3][r*3+1]) + 66'(p1_reg[r*3+0]) + 66'(p1_reg[r*3+1])
                  + 66'(p1_reg[r*3+2]);
            s2[r] = 66'(m_t[T_FAC+5][r*3+2]) + 66'(p2_reg[r*3+0]) + 66'(p2_reg[r*3+1])
                  + 66'(p2_reg[r*3+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                r0_reg[r] <= (s0[r] > S_MAX) ? ENT_W'(S_MAX) :
                             (s0[r] < S_MIN) ? ENT_W'(S_MIN) : ENT_W'(s0[r]);
                // column 1: e01 * new c0, e11 * c1, e12 * c2
                p1_reg[r*3+0] <= (64'(e2_reg[3]) * 64'(r0_reg[r])) >>> FRAC_BITS;
                p1_reg[r*3+1] <= (64'(e2_reg[1]) * 64'(m_t[T_FAC+2][r*3+1])) >>> FRAC_BITS;
                p1_reg[r*3+2] <= (64'(e2_reg[5]) * 64'(m_t[T_FAC+2][r*3+2])) >>> FRAC_BITS;
                r1_reg[r] <= (s1[r] > S_MAX) ? ENT_W'(S_MAX) :
                             (s1[r] < S_MIN) ? ENT_W'(S_MIN) : ENT_W'(s1[r]);
            end
        end
    end

    ent_t r0d_reg [3];
    ent_t r0dd_reg [3];

    // column 2: e02 * new c0, e12 * new c1, e22 * c2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0d_reg  <= r0_reg;
            r0dd_reg <= r0d_reg;
            for (int r = 0; r < 3; r++)
            begin
                p2_reg[r*3+0] <= (64'(e4_reg[4]) * 64'(r0dd_reg[r])) >>> FRAC_BITS;
                p2_reg[r*3+1] <= (64'(e4_reg[5]) * 64'(r1_reg[r])) >>> FRAC_BITS;
                p2_reg[r*3+2] <= (64'(e4_reg[2]) * 64'(m_t[T_FAC+4][r*3+2])) >>> FRAC_BITS;
            end
        end
    end

    ent_t r0e_reg [3];
    ent_t r1d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0e_reg <= r0dd_reg;
            r1d_reg <= r1_reg;
        end
    end

    // final clamp, or pass through on a zero divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_out_reg <= car_reg[CAR_N-1].deg;
            for (int r = 0; r < 3; r++)
            begin
                logic signed [65:0] v [3];
                v[0] = 66'(r0e_reg[r]);
                v[1] = 66'(r1d_reg[r]);
                v[2] = (s2[r] > S_MAX) ? S_MAX : (s2[r] < S_MIN) ? S_MIN : s2[r];
                for (int c = 0; c < 3; c++)
                begin
                    if (car_reg[CAR_N-1].deg)
                    begin
                        out_reg[(r*3+c)*ENT_W +: ENT_W] <= m_t[CAR_N-1][r*3+c];
                    end
                    else
                    begin
                        out_reg[(r*3+c)*ENT_W +: ENT_W] <=
                            (v[c] > ONE) ? ENT_W'(ONE) :
                            (v[c] < -ONE) ? ENT_W'(-ONE) : ENT_W'(v[c]);
                    end
                end
            end
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted request not captured");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            ($signed(m_axis_tdata[ENT_W-1:0]) <= ENT_W'(ONE) &&
             $signed(m_axis_tdata[ENT_W-1:0]) >= ENT_W'(-ONE)))
        else $error("result entry outside unit range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAT-1] && !m_axis_tready) |=> vld_reg[LAT-1] && $stable(out_reg))
        else $error("stalled result changed");

endmodule
